// ----- src/ccir_pkg.sv -----
// Shared constants and state types for the coprime range counter.
package ccir_pkg;

	// Fixed field widths of the query and result transactions
	localparam int RANGE_BITS   = 50;
	localparam int MODULUS_BITS = 32;

	typedef enum logic [2:0] {
		SV_CLEAR,
		SV_RD,
		SV_TEST,
		SV_MARK,
		SV_SCAN_RD,
		SV_SCAN,
		SV_READY
	} sieve_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_PRD,
		C_PCHK,
		C_PDIV,
		C_RESID,
		C_FRD,
		C_FMUL,
		C_DIVH,
		C_WH,
		C_WL,
		C_DONE
	} core_state_t;

endpackage

// ----- src/ccir_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, optional narrow dividend.
module ccir_div #(
	parameter int NW     = 50,
	parameter int DW     = 32,
	parameter int NARROW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          narrow,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quot,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= narrow ? CW'(NARROW) : CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q  <= narrow ? (dividend << (NW - NARROW)) : dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NW-2:0], 1'b0};
			quot_q <= {quot_q[NW-2:0], ge};
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ----- src/ccir_sieve.sv -----
// Sieve over a mark memory that fills the prime table after reset; table read port.
module ccir_sieve #(
	parameter int PRIME_LIMIT = 65536
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic [$clog2(PRIME_LIMIT/2+1)-1:0]            rd_addr,
	output logic [$clog2(PRIME_LIMIT)-1:0]                rd_data,
	output logic [$clog2(PRIME_LIMIT/2+2)-1:0]            total,
	output logic                                          ready
);
	localparam int PB    = $clog2(PRIME_LIMIT);
	localparam int LW    = PB + 1;
	localparam int DEPTH = PRIME_LIMIT / 2 + 1;
	localparam int TA    = $clog2(DEPTH);
	localparam int TCW   = $clog2(DEPTH + 1);

	ccir_pkg::sieve_state_t state_q, state_d;

	logic          mark_mem [PRIME_LIMIT];
	logic          mark_rd_q;
	logic [PB-1:0] ptab_mem [DEPTH];
	logic [PB-1:0] ptab_rd_q;

	logic [LW-1:0]   i_q;
	logic [LW-1:0]   j_q;
	logic [LW-1:0]   s_q;
	logic [TCW-1:0]  total_q;
	logic [2*LW-1:0] sq;
	logic            sq_over;
	logic [LW-1:0]   j_next;

	assign sq      = i_q * i_q;
	assign sq_over = sq >= (2*LW)'(PRIME_LIMIT);
	assign j_next  = j_q + i_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccir_pkg::SV_CLEAR:   if (s_q == LW'(PRIME_LIMIT - 1)) state_d = ccir_pkg::SV_RD;
			ccir_pkg::SV_RD:      state_d = ccir_pkg::SV_TEST;
			ccir_pkg::SV_TEST: begin
				priority if (sq_over) state_d = ccir_pkg::SV_SCAN_RD;
				else if (!mark_rd_q)  state_d = ccir_pkg::SV_MARK;
				else                  state_d = ccir_pkg::SV_RD;
			end
			ccir_pkg::SV_MARK:    if (j_next >= LW'(PRIME_LIMIT)) state_d = ccir_pkg::SV_RD;
			ccir_pkg::SV_SCAN_RD: state_d = ccir_pkg::SV_SCAN;
			ccir_pkg::SV_SCAN: begin
				if (s_q == LW'(PRIME_LIMIT - 1)) state_d = ccir_pkg::SV_READY;
				else                             state_d = ccir_pkg::SV_SCAN_RD;
			end
			ccir_pkg::SV_READY:   state_d = ccir_pkg::SV_READY;
			default:              state_d = ccir_pkg::SV_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccir_pkg::SV_CLEAR;
			i_q     <= LW'(2);
			j_q     <= '0;
			s_q     <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ccir_pkg::SV_CLEAR: s_q <= (s_q == LW'(PRIME_LIMIT - 1)) ? '0 : s_q + LW'(1);
				ccir_pkg::SV_TEST: begin
					if (sq_over)         s_q <= LW'(2);
					else if (!mark_rd_q) j_q <= sq[LW-1:0];
					else                 i_q <= i_q + LW'(1);
				end
				ccir_pkg::SV_MARK: begin
					j_q <= j_next;
					if (j_next >= LW'(PRIME_LIMIT)) i_q <= i_q + LW'(1);
				end
				ccir_pkg::SV_SCAN: begin
					if (!mark_rd_q && total_q < TCW'(DEPTH)) total_q <= total_q + TCW'(1);
					s_q <= s_q + LW'(1);
				end
				default: ;
			endcase
		end
	end

	// Mark memory: zero means still a candidate prime
	always_ff @(posedge clk) begin
		if (state_q == ccir_pkg::SV_CLEAR) mark_mem[s_q[PB-1:0]] <= 1'b0;
		if (state_q == ccir_pkg::SV_MARK)  mark_mem[j_q[PB-1:0]] <= 1'b1;
		if (state_q == ccir_pkg::SV_RD)    mark_rd_q <= mark_mem[i_q[PB-1:0]];
		if (state_q == ccir_pkg::SV_SCAN_RD) mark_rd_q <= mark_mem[s_q[PB-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ccir_pkg::SV_SCAN && !mark_rd_q && total_q < TCW'(DEPTH))
			ptab_mem[total_q[TA-1:0]] <= s_q[PB-1:0];
		ptab_rd_q <= ptab_mem[rd_addr];
	end

	assign rd_data = ptab_rd_q;
	assign total   = total_q;
	assign ready   = state_q == ccir_pkg::SV_READY;
endmodule

// ----- src/ccir_core.sv -----
// Query sequencer: trial division over the prime table, then inclusion-exclusion.
module ccir_core #(
	parameter int PRIME_LIMIT = 65536,
	parameter int MAX_FACTORS = 9
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   table_ready,
	input  logic [$clog2(PRIME_LIMIT/2+2)-1:0]     prime_total,
	output logic [$clog2(PRIME_LIMIT/2+1)-1:0]     ptab_addr,
	input  logic [$clog2(PRIME_LIMIT)-1:0]         ptab_data,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [ccir_pkg::RANGE_BITS-1:0]        range_low,
	input  logic [ccir_pkg::RANGE_BITS-1:0]        range_high,
	input  logic [ccir_pkg::MODULUS_BITS-1:0]      modulus_n,
	output logic                                   done,
	output logic [ccir_pkg::RANGE_BITS-1:0]        coprime_count,
	output logic                                   bad_range
);
	localparam int RB  = ccir_pkg::RANGE_BITS;
	localparam int MB  = ccir_pkg::MODULUS_BITS;
	localparam int SW  = RB + 2;
	localparam int PB  = $clog2(PRIME_LIMIT);
	localparam int TA  = $clog2(PRIME_LIMIT / 2 + 1);
	localparam int TCW = $clog2(PRIME_LIMIT / 2 + 2);
	localparam int MW  = MAX_FACTORS;
	localparam int FW  = $clog2(MAX_FACTORS + 1);
	localparam int FA  = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
	localparam int CW  = (2 * PB > MB) ? 2 * PB : MB;

	ccir_pkg::core_state_t state_q, state_d;

	logic [MB-1:0] fmem [MAX_FACTORS];
	logic [MB-1:0] frd_q;

	logic [RB-1:0]  lo_q, hi_q, qh_q;
	logic [MB-1:0]  rem_q, prod_q;
	logic [TCW-1:0] idx_q;
	logic [PB-1:0]  p_q;
	logic           found_q, par_q, bad_q;
	logic [FW-1:0]  nf_q, k_q;
	logic [MW-1:0]  mask_q;
	logic [SW-1:0]  sum_q;
	logic [RB-1:0]  count_q;

	logic          accept, in_bad;
	logic [2*PB-1:0] pp;
	logic          p_big, resid_add, last_mask, f_we;
	logic [MB-1:0] f_wdata;
	logic [MW:0]   mask_lim;
	logic [RB-1:0] qdiff;
	logic [SW-1:0] sum_new;
	logic [MB-1:0] prod_full;

	logic          div_start, div_narrow, div_done;
	logic [RB-1:0] div_num, div_quot;
	logic [MB-1:0] div_den, div_rem;

	assign busy      = !table_ready || state_q != ccir_pkg::C_IDLE;
	assign accept    = start && !busy;
	assign in_bad    = range_low == '0 || range_low > range_high;
	assign pp        = ptab_data * ptab_data;
	assign p_big     = CW'(pp) > CW'(rem_q);
	assign resid_add = rem_q > MB'(1) && nf_q < FW'(MAX_FACTORS);
	assign mask_lim  = (MW+1)'(1) << nf_q;
	assign last_mask = ({1'b0, mask_q} + (MW+1)'(1)) == mask_lim;
	assign qdiff     = qh_q - div_quot;
	assign sum_new   = par_q ? sum_q - SW'(qdiff) : sum_q + SW'(qdiff);
	// A subset product divides the modulus, so it always fits the modulus width
	assign prod_full = prod_q * frd_q;
	assign ptab_addr = idx_q[TA-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccir_pkg::C_IDLE: begin
				if (accept) begin
					if (in_bad || modulus_n == '0) state_d = ccir_pkg::C_DONE;
					else                           state_d = ccir_pkg::C_PRD;
				end
			end
			ccir_pkg::C_PRD:
				state_d = (idx_q == prime_total) ? ccir_pkg::C_RESID : ccir_pkg::C_PCHK;
			ccir_pkg::C_PCHK:
				state_d = p_big ? ccir_pkg::C_RESID : ccir_pkg::C_PDIV;
			ccir_pkg::C_PDIV:
				if (div_done && div_rem != '0) state_d = ccir_pkg::C_PRD;
			ccir_pkg::C_RESID:
				state_d = (nf_q == '0 && !resid_add) ? ccir_pkg::C_DONE : ccir_pkg::C_FRD;
			ccir_pkg::C_FRD:
				state_d = (k_q == nf_q) ? ccir_pkg::C_DIVH : ccir_pkg::C_FMUL;
			ccir_pkg::C_FMUL: state_d = ccir_pkg::C_FRD;
			ccir_pkg::C_DIVH: state_d = ccir_pkg::C_WH;
			ccir_pkg::C_WH:   if (div_done) state_d = ccir_pkg::C_WL;
			ccir_pkg::C_WL:
				if (div_done) state_d = last_mask ? ccir_pkg::C_DONE : ccir_pkg::C_FRD;
			ccir_pkg::C_DONE: state_d = ccir_pkg::C_IDLE;
			default:          state_d = ccir_pkg::C_IDLE;
		endcase
	end

	// Divider requests and factor writes
	always_comb begin
		div_start  = 1'b0;
		div_narrow = 1'b0;
		div_num    = RB'(rem_q);
		div_den    = MB'(ptab_data);
		f_we       = 1'b0;
		f_wdata    = MB'(p_q);
		unique case (state_q)
			ccir_pkg::C_PCHK: begin
				div_start  = !p_big;
				div_narrow = 1'b1;
			end
			ccir_pkg::C_PDIV: begin
				div_narrow = 1'b1;
				div_num    = RB'(div_quot[MB-1:0]);
				div_den    = MB'(p_q);
				div_start  = div_done && div_rem == '0;
				f_we       = div_start && !found_q && nf_q < FW'(MAX_FACTORS);
			end
			ccir_pkg::C_RESID: begin
				f_we    = resid_add;
				f_wdata = rem_q;
			end
			ccir_pkg::C_DIVH: begin
				div_start = 1'b1;
				div_num   = hi_q;
				div_den   = prod_q;
			end
			ccir_pkg::C_WH: begin
				div_start = div_done;
				div_num   = lo_q - RB'(1);
				div_den   = prod_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		done          = state_q == ccir_pkg::C_DONE;
		coprime_count = count_q;
		bad_range     = bad_q;
	end

	// Factor memory: every write of a query lands before its first read
	always_ff @(posedge clk) begin
		if (f_we) fmem[nf_q[FA-1:0]] <= f_wdata;
		if (state_q == ccir_pkg::C_FRD && k_q != nf_q) frd_q <= fmem[k_q[FA-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccir_pkg::C_IDLE;
			bad_q   <= 1'b0;
			nf_q    <= '0;
			mask_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ccir_pkg::C_IDLE: begin
					if (accept) begin
						lo_q    <= range_low;
						hi_q    <= range_high;
						rem_q   <= modulus_n;
						idx_q   <= '0;
						nf_q    <= '0;
						found_q <= 1'b0;
						bad_q   <= in_bad;
						count_q <= (!in_bad && range_low == RB'(1)) ? RB'(1) : '0;
					end
				end
				ccir_pkg::C_PCHK: p_q <= ptab_data;
				ccir_pkg::C_PDIV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							rem_q   <= div_quot[MB-1:0];
							found_q <= 1'b1;
							if (f_we) nf_q <= nf_q + FW'(1);
						end else begin
							found_q <= 1'b0;
							idx_q   <= idx_q + TCW'(1);
						end
					end
				end
				ccir_pkg::C_RESID: begin
					if (resid_add) nf_q <= nf_q + FW'(1);
					sum_q   <= SW'(hi_q) - SW'(lo_q) + SW'(1);
					count_q <= hi_q - lo_q + RB'(1);
					mask_q  <= MW'(1);
					k_q     <= '0;
					prod_q  <= MB'(1);
					par_q   <= 1'b0;
				end
				ccir_pkg::C_FMUL: begin
					if (mask_q[k_q[FA-1:0]]) begin
						prod_q <= prod_full;
						par_q  <= !par_q;
					end
					k_q <= k_q + FW'(1);
				end
				ccir_pkg::C_WH: if (div_done) qh_q <= div_quot;
				ccir_pkg::C_WL: begin
					if (div_done) begin
						sum_q   <= sum_new;
						count_q <= sum_new[RB-1:0];
						mask_q  <= mask_q + MW'(1);
						k_q     <= '0;
						prod_q  <= MB'(1);
						par_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	ccir_div #(
		.NW     (RB),
		.DW     (MB),
		.NARROW (MB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.narrow   (div_narrow),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);
endmodule

// ----- src/coprime_count_in_range_top.sv -----
// Top level of the coprime range counter: prime sieve plus query sequencer.
//
// Usage
//   Query channel: drive range_low, range_high and modulus_n and raise start.
//   The transaction is taken at the rising edge where start is high and busy
//   is low; busy then stays high until the result has been shown.
//   Result channel: done is high for exactly one cycle with coprime_count and
//   bad_range valid. The receiver cannot stall; take the result that cycle.
// Query flow
//   A bad range (low zero or above high) or a zero modulus shows its result in
//   the cycle right after the accepting edge.
//   Otherwise trial division runs over the table primes (one narrow 32-bit
//   pass of the shared divider per prime and per repeated factor),
//   stopping once p*p exceeds the remainder. Inclusion-exclusion then runs
//   once per subset of the k factors (two 50-bit divisions),
//   2^k - 1 subsets.
//   One query is in flight at a time; the divider sets the pace.
// Reset
//   After arst_n releases, the sieve clears its mark memory, strikes
//   composites and scans the marks into the prime table; busy holds high
//   until then.
module coprime_count_in_range_top #(
	parameter int PRIME_LIMIT = 65536,
	parameter int MAX_FACTORS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ccir_pkg::RANGE_BITS-1:0]   range_low,
	input  logic [ccir_pkg::RANGE_BITS-1:0]   range_high,
	input  logic [ccir_pkg::MODULUS_BITS-1:0] modulus_n,
	output logic                              done,
	output logic [ccir_pkg::RANGE_BITS-1:0]   coprime_count,
	output logic                              bad_range
);
	localparam int PB  = $clog2(PRIME_LIMIT);
	localparam int TA  = $clog2(PRIME_LIMIT / 2 + 1);
	localparam int TCW = $clog2(PRIME_LIMIT / 2 + 2);

	// Prime table read port and fill status
	logic [TA-1:0]  ptab_addr;
	logic [PB-1:0]  ptab_data;
	logic [TCW-1:0] prime_total;
	logic           table_ready;

	ccir_sieve #(
		.PRIME_LIMIT (PRIME_LIMIT)
	) u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (ptab_addr),
		.rd_data (ptab_data),
		.total   (prime_total),
		.ready   (table_ready)
	);

	// Sequencer holds each query transaction until its result is shown
	ccir_core #(
		.PRIME_LIMIT (PRIME_LIMIT),
		.MAX_FACTORS (MAX_FACTORS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.table_ready   (table_ready),
		.prime_total   (prime_total),
		.ptab_addr     (ptab_addr),
		.ptab_data     (ptab_data),
		.start         (start),
		.busy          (busy),
		.range_low     (range_low),
		.range_high    (range_high),
		.modulus_n     (modulus_n),
		.done          (done),
		.coprime_count (coprime_count),
		.bad_range     (bad_range)
	);
endmodule

// ----- src/ccir_chk.sv -----
// Port-level checks for the coprime range counter, bound to the top level.
module ccir_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [ccir_pkg::RANGE_BITS-1:0] coprime_count,
	input logic                            bad_range
);
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_range |-> coprime_count == '0)
		else $error("bad range result with non-zero count");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");
endmodule

bind coprime_count_in_range_top ccir_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.coprime_count (coprime_count),
	.bad_range     (bad_range)
);

// ----- verif/tb_coprime_count_in_range_top.sv -----
// Self-checking testbench for the coprime range counter top level.
`timescale 1ns / 100ps

module tb_coprime_count_in_range_top;

	localparam longint unsigned RANGE_MAX = (64'd1 << ccir_pkg::RANGE_BITS) - 1;
	localparam longint unsigned MOD_LIMIT = 64'd1 << ccir_pkg::MODULUS_BITS;
	localparam int              MAX_FACTORS = 9;

	typedef struct {
		logic [ccir_pkg::RANGE_BITS-1:0] count;
		logic                            bad;
	} coprime_answer_t;

	// Scoreboard: predicts the answer of each query and compares it with the block
	class coprime_scoreboard;
		coprime_answer_t pending[$];
		longint unsigned factors[MAX_FACTORS];
		int              nfact;
		int              errors;
		int              checked;

		// Drop repeated prime factors of n; a leftover above 1 is a factor as it is
		function void factorise(longint unsigned n);
			longint unsigned rem;
			longint unsigned p;
			rem   = n;
			nfact = 0;
			for (p = 2; p * p <= rem; p++) begin
				if (rem % p == 0) begin
					if (nfact < MAX_FACTORS) begin
						factors[nfact] = p;
						nfact++;
					end
					while (rem % p == 0)
						rem = rem / p;
				end
			end
			if (rem > 1 && nfact < MAX_FACTORS) begin
				factors[nfact] = rem;
				nfact++;
			end
		endfunction

		// Inclusion-exclusion: x minus multiples of each factor, plus pairs, and so on
		function longint alternating_floor_sum(longint unsigned x);
			longint          sum;
			longint unsigned prod;
			int              bits;
			sum = longint'(x);
			for (int m = 1; m < (1 << nfact); m++) begin
				prod = 1;
				bits = 0;
				for (int k = 0; k < nfact; k++)
					if (m[k]) begin
						prod = prod * factors[k];
						bits++;
					end
				if (bits % 2 == 1)
					sum = sum - longint'(x / prod);
				else
					sum = sum + longint'(x / prod);
			end
			return sum;
		endfunction

		function void note_query(longint unsigned lo, longint unsigned hi, longint unsigned n);
			coprime_answer_t a;
			longint          diff;
			a.bad   = 1'b0;
			a.count = '0;
			if (lo == 0 || lo > hi)
				a.bad = 1'b1;
			else if (n == 0)
				a.count = (lo == 1) ? 1 : 0;
			else begin
				factorise(n);
				diff    = alternating_floor_sum(hi) - alternating_floor_sum(lo - 1);
				a.count = diff[ccir_pkg::RANGE_BITS-1:0];
			end
			pending = {pending, a};
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task check_answer(logic [ccir_pkg::RANGE_BITS-1:0] count, logic bad);
			coprime_answer_t e;
			checked++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result count=%0d bad=%0b", count, bad));
				return;
			end
			e = pending.pop_front();
			if (count !== e.count)
				report($sformatf("coprime_count %0d, predicted %0d", count, e.count));
			if (bad !== e.bad)
				report($sformatf("bad_range %0b, predicted %0b", bad, e.bad));
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [ccir_pkg::RANGE_BITS-1:0]   range_low;
	logic [ccir_pkg::RANGE_BITS-1:0]   range_high;
	logic [ccir_pkg::MODULUS_BITS-1:0] modulus_n;
	logic                              done;
	logic [ccir_pkg::RANGE_BITS-1:0]   coprime_count;
	logic                              bad_range;

	coprime_scoreboard sb;
	int                idle_pct;
	int                sent;

	// Small primes used to build moduli whose trial division ends quickly
	longint unsigned small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

	coprime_count_in_range_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.range_low    (range_low),
		.range_high   (range_high),
		.modulus_n    (modulus_n),
		.done         (done),
		.coprime_count(coprime_count),
		.bad_range    (bad_range)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every cycle with done high carries a result; the receiver cannot hold it off
	always @(posedge clk)
		if (arst_n && done)
			sb.check_answer(coprime_count, bad_range);

	// Hold the query until busy is low at a falling edge, then raise start for one edge
	task send_query(longint unsigned lo, longint unsigned hi, longint unsigned n);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		while (busy)
			@(negedge clk);
		range_low  = lo[ccir_pkg::RANGE_BITS-1:0];
		range_high = hi[ccir_pkg::RANGE_BITS-1:0];
		modulus_n  = n[ccir_pkg::MODULUS_BITS-1:0];
		start      = 1'b1;
		@(negedge clk);
		// busy was low through the rising edge, so the transaction was taken
		sb.note_query(lo & RANGE_MAX, hi & RANGE_MAX, n & (MOD_LIMIT - 1));
		start = 1'b0;
		sent++;
	endtask

	// Modulus from random powers of small primes, now and then times a random residual
	function longint unsigned random_modulus();
		longint unsigned n;
		longint unsigned r;
		n = 1;
		for (int i = 0; i < 12; i++)
			if ($urandom_range(99) < 35)
				for (int e = $urandom_range(3, 1); e > 0; e--)
					if (n * small_primes[i] < MOD_LIMIT)
						n = n * small_primes[i];
		if ($urandom_range(1)) begin
			r = $urandom_range(65535, 2);
			if (n * r < MOD_LIMIT)
				n = n * r;
		end
		return n;
	endfunction

	task send_random_query();
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned t;
		longint unsigned n;
		int              pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			// short range at the bottom
			lo = $urandom_range(1000, 1);
			hi = lo + $urandom_range(5000);
		end else if (pick < 85) begin
			// anywhere in the full width
			lo = {$urandom, $urandom} & RANGE_MAX;
			hi = {$urandom, $urandom} & RANGE_MAX;
			if (lo > hi) begin
				t  = lo;
				lo = hi;
				hi = t;
			end
			if (lo == 0)
				lo = 1;
		end else if (pick < 95) begin
			// broken range: low above high
			hi = {$urandom, $urandom} & RANGE_MAX >> $urandom_range(40);
			lo = hi + $urandom_range(1000, 1);
		end else begin
			lo = 0;
			hi = {$urandom, $urandom} & RANGE_MAX;
		end
		pick = $urandom_range(99);
		if (pick < 4)
			n = 0;
		else if (pick < 8)
			n = 1;
		else
			n = random_modulus();
		send_query(lo, hi, n);
	endtask

	initial begin
		sb         = new();
		idle_pct   = 0;
		sent       = 0;
		start      = 1'b0;
		range_low  = '0;
		range_high = '0;
		modulus_n  = '0;
		arst_n     = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: broken ranges, zero and unit moduli, field extremes, nine factors
		send_query(0, 5, 6);
		send_query(0, 0, 7);
		send_query(10, 3, 6);
		send_query(RANGE_MAX, RANGE_MAX - 1, 30);
		send_query(1, 1, 0);
		send_query(1, RANGE_MAX, 0);
		send_query(2, 100, 0);
		send_query(1, RANGE_MAX, 1);
		send_query(RANGE_MAX, RANGE_MAX, 64'hFFFF_FFFF);
		send_query(1, RANGE_MAX, 64'hFFFF_FFFF);
		send_query(1, RANGE_MAX, 223092870);
		send_query(12345, 67890, 223092870);
		send_query(1, 1000, 64'h8000_0000);
		send_query(RANGE_MAX >> 1, RANGE_MAX, 97 * 65521);
		// prime near the top of the modulus range: the longest trial division
		send_query(1, 1000, 4294967291);
		send_query(1, 1, 2);
		send_query(2, 2, 2);

		// Random phases: back to back, sparse sender, light idling
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 0 : (phase == 1) ? 80 : 11;
			repeat (28)
				send_random_query();
			if (phase == 1)
				// pause until every outstanding transaction has answered
				while (sb.pending.size() != 0)
					@(negedge clk);
		end

		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d queries (%0d results checked): broken ranges,",
			sent, sb.checked);
		$display("zero and unit moduli, full-width ranges, nine-factor and large-prime moduli,");
		$display("with and without idling.");
		if (sb.errors == 0)
			$display("tb_coprime_count_in_range_top: done, clean");
		else
			$display("tb_coprime_count_in_range_top: done, errors");
		$finish;
	end

	// Generous ceiling: sieve after reset, one long trial division, the rest
	initial begin
		#100_000_000;
		$display("Timeout with %0d results still outstanding", sb.pending.size());
		$display("tb_coprime_count_in_range_top: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ccir_pkg.sv
src/ccir_div.sv
src/ccir_sieve.sv
src/ccir_core.sv
src/coprime_count_in_range_top.sv
src/ccir_chk.sv
verif/tb_coprime_count_in_range_top.sv
